FILE: rtl/wps_pkg.sv
// ----------------------------------------------------------------------------
// window position statistics package
// shared widths, item types and result field offsets
// ----------------------------------------------------------------------------
package wps_pkg;

	localparam int MaxWindowDef = 1024;
	localparam int WlResetMax   = 1024;
	localparam int PosW         = 32;
	localparam int CfgW         = 11;
	localparam int VsW          = 11;
	localparam int InDataW      = 3 * PosW;
	localparam int ResW         = 7 * PosW + VsW;
	localparam int OutDataW     = ((ResW + 7) / 8) * 8;
	localparam int OffDev       = 3 * PosW;
	localparam int OffVs        = 7 * PosW;

	typedef enum logic {
		CMD_PUSH   = 1'b0,
		CMD_REPORT = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [PosW-1:0]  sum_level;
		logic [PosW-1:0]  z_pos;
		logic [PosW-1:0]  x_pos;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

FILE: rtl/window_position_statistics_top.sv
// ----------------------------------------------------------------------------
// window position statistics
// sliding window mean, sample deviation and span of beam position samples
//
// s_* channel: one item per transfer, s_tuser is the mode (0 push, 1 report),
// s_tdata carries x_pos, z_pos and sum_level. m_* channel: one result per
// report. cfg_* channel: writes window_length and empties the window.
// A two-entry queue parts the front end from the back end, and a result
// register parts the back end from m_*, so pushes keep flowing while a
// result waits for m_tready.
// A push in the back end is one history memory write.
// A report with n valid samples walks over the history memory at one entry
// per cycle, then runs five divisions on the shared bit-serial divider, two
// shift-add products per channel and two 32-step square roots.
// Reset empties the window, sets window_length to 1024 (or MAX_WINDOW if
// smaller) and drops any queued item; the history needs no clearing.
// When m_tready is low a finished result stays on m_tdata and the next
// report waits in the back end until it is taken.
// ----------------------------------------------------------------------------
module window_position_statistics_top #(
	parameter int MAX_WINDOW = wps_pkg::MaxWindowDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [wps_pkg::InDataW-1:0]   s_tdata,   // x_pos, z_pos, sum_level
	input  logic [0:0]                    s_tuser,   // mode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// x_mean, z_mean, sum_mean, x_deviation, z_deviation, x_span, z_span, valid_samples
	output logic [wps_pkg::OutDataW-1:0]  m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wps_pkg::CfgW-1:0]      cfg_data
);
	import wps_pkg::*;

	queue_head_t head;
	logic        pop;

	wps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.head     (head),
		.pop      (pop)
	);

	wps_back #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

FILE: rtl/wps_front.sv
// ----------------------------------------------------------------------------
// window position statistics front end
// accepts items, classifies push or report and queues them for the back end
// ----------------------------------------------------------------------------
module wps_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [wps_pkg::InDataW-1:0]       s_tdata,  // x_pos, z_pos, sum_level
	input  logic [0:0]                        s_tuser,  // mode
	output wps_pkg::queue_head_t              head,
	input  logic                              pop
);
	import wps_pkg::*;

	localparam int Depth = 2;
	localparam int CntW  = $clog2(Depth + 1);

	item_t           slot_q [Depth];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            take;
	logic            give;
	item_t           in_item;

	always_comb begin
		in_item.cmd       = cmd_t'(s_tuser[0]);
		in_item.x_pos     = s_tdata[PosW-1:0];
		in_item.z_pos     = s_tdata[2*PosW-1:PosW];
		in_item.sum_level = s_tdata[3*PosW-1:2*PosW];
	end

	assign s_tready   = count_q != CntW'(Depth);
	assign take       = s_tvalid && s_tready;
	assign head.valid = count_q != '0;
	assign head.item  = slot_q[rd_ptr_q];
	assign give       = pop && head.valid;

	always_ff @(posedge clk) begin
		if (take) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (take) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (give) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({take, give})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/wps_div.sv
// ----------------------------------------------------------------------------
// window position statistics divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wps_div #(
	parameter int DW  = 86,
	parameter int DVW = 22
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DW-1:0]  dividend,
	input  logic [DVW-1:0] divisor,
	output logic           done,
	output logic [DW-1:0]  quotient
);
	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DVW-1:0] den_q;
	logic [DVW-1:0] rem_q;
	logic [DW-1:0]  quot_q;
	logic [DVW:0]   shifted;
	logic [DVW:0]   diff;
	logic           fits;

	assign shifted  = {rem_q, quot_q[DW-1]};
	assign diff     = shifted - {1'b0, den_q};
	assign fits     = shifted >= {1'b0, den_q};
	assign done     = done_q;
	assign quotient = quot_q;

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= divisor;
			rem_q  <= '0;
			quot_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DVW-1:0] : shifted[DVW-1:0];
			quot_q <= {quot_q[DW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: rtl/wps_sqrt.sv
// ----------------------------------------------------------------------------
// window position statistics square root
// floored square root of a 64-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module wps_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	localparam int Steps = 32;
	localparam int CW    = $clog2(Steps + 1);

	logic [63:0]   rem_q;
	logic [63:0]   res_q;
	logic [63:0]   bit_q;
	logic [63:0]   trial;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	assign trial = res_q + bit_q;
	assign done  = done_q;
	assign root  = res_q[31:0];

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= 64'(1) << 62;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(Steps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: rtl/wps_back.sv
// ----------------------------------------------------------------------------
// window position statistics back end
// sample history, window walk, mean, deviation and span, result register
// ----------------------------------------------------------------------------
module wps_back #(
	parameter int MAX_WINDOW = wps_pkg::MaxWindowDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wps_pkg::queue_head_t          head,
	output logic                          pop,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wps_pkg::CfgW-1:0]      cfg_data,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [wps_pkg::OutDataW-1:0]  m_tdata
);
	import wps_pkg::*;

	localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int NW      = $clog2(MAX_WINDOW + 1);
	localparam int SW      = PosW + NW;
	localparam int QW      = 2 * PosW - 2 + NW;
	localparam int VW      = 2 * PosW - 2 + 2 * NW;
	localparam int DVW     = 2 * NW;
	localparam int WlReset = (WlResetMax < MAX_WINDOW) ? WlResetMax : MAX_WINDOW;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK,
		ST_MEAN_X,
		ST_MEAN_Z,
		ST_MEAN_S,
		ST_VMUL,
		ST_VSQ,
		ST_VDIV,
		ST_VSQRT,
		ST_DONE
	} state_t;

	function automatic logic [NW-1:0] clamp_wl(input logic [CfgW-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		if (w == 32'd0) w = 32'd1;
		if (w > 32'(MAX_WINDOW)) w = 32'(MAX_WINDOW);
		return NW'(w);
	endfunction

	state_t            state_q;
	logic              wait_q;
	logic              ch_q;
	logic [NW-1:0]     wl_q;
	logic [AW-1:0]     ws_q;
	logic [NW-1:0]     vc_q;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     rem_cnt_q;
	logic [AW-1:0]     rd_ptr_q;
	logic              first_q;
	logic              v_s1;
	logic              v_s2;
	logic              m_tvalid_q;
	logic [OutDataW-1:0] m_tdata_q;

	logic [InDataW-1:0] mem_q [MAX_WINDOW];
	logic [InDataW-1:0] rdata_s1;
	logic [PosW-1:0]    x_s2, z_s2, sum_s2;
	logic [63:0]        sqx_s2, sqz_s2;

	logic [SW-1:0]     sx_q, sz_q, ssum_q;
	logic [QW-1:0]     sqx_q, sqz_q;
	logic [PosW-1:0]   xhi_q, xlo_q, zhi_q, zlo_q;
	logic [DVW-1:0]    nn1_q;
	logic [VW-1:0]     acc_q, mcand_q;
	logic [SW-1:0]     mplier_q;
	logic [63:0]       var_q;
	logic [PosW-1:0]   x_mean_q, z_mean_q, s_mean_q, x_dev_q, z_dev_q, x_span_q, z_span_q;

	logic [AW-1:0]     wl_last;
	logic              mem_we;
	logic              mem_re;
	logic [PosW-1:0]   rx, rz, ax, az;
	logic [SW-1:0]     sxa, sza, sa;
	logic              div_start, div_done, sqrt_start, sqrt_done;
	logic [VW-1:0]     div_dvd, div_q;
	logic [DVW-1:0]    div_dvs;
	logic [31:0]       sqrt_root;

	assign wl_last   = AW'(wl_q - NW'(1));
	assign pop       = head.valid && (state_q == ST_IDLE);
	assign mem_we    = pop && (head.item.cmd == CMD_PUSH);
	assign mem_re    = (state_q == ST_WALK) && (rem_cnt_q != '0);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign rx  = rdata_s1[PosW-1:0];
	assign rz  = rdata_s1[2*PosW-1:PosW];
	assign ax  = rx[PosW-1] ? (~rx + PosW'(1)) : rx;
	assign az  = rz[PosW-1] ? (~rz + PosW'(1)) : rz;
	assign sxa = sx_q[SW-1] ? (~sx_q + SW'(1)) : sx_q;
	assign sza = sz_q[SW-1] ? (~sz_q + SW'(1)) : sz_q;
	assign sa  = ch_q ? sza : sxa;

	always_comb begin
		case (state_q)
			ST_MEAN_X: div_dvd = VW'(sxa);
			ST_MEAN_Z: div_dvd = VW'(sza);
			ST_MEAN_S: div_dvd = VW'(ssum_q);
			default:   div_dvd = acc_q;
		endcase
		div_dvs    = (state_q == ST_VDIV) ? nn1_q : DVW'(n_q);
		div_start  = !wait_q && (state_q == ST_MEAN_X || state_q == ST_MEAN_Z ||
			state_q == ST_MEAN_S || state_q == ST_VDIV);
		sqrt_start = !wait_q && (state_q == ST_VSQRT);
	end

	wps_div #(
		.DW  (VW),
		.DVW (DVW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	wps_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (var_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// history memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[ws_q] <= {head.item.sum_level, head.item.z_pos, head.item.x_pos};
		end
		if (mem_re) begin
			rdata_s1 <= mem_q[rd_ptr_q];
		end
	end

	// squares stage
	always_ff @(posedge clk) begin
		x_s2   <= rx;
		z_s2   <= rz;
		sum_s2 <= rdata_s1[3*PosW-1:2*PosW];
		sqx_s2 <= ax * ax;
		sqz_s2 <= az * az;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wait_q     <= 1'b0;
			ch_q       <= 1'b0;
			wl_q       <= NW'(WlReset);
			ws_q       <= '0;
			vc_q       <= '0;
			n_q        <= '0;
			rem_cnt_q  <= '0;
			rd_ptr_q   <= '0;
			first_q    <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			sx_q       <= '0;
			sz_q       <= '0;
			ssum_q     <= '0;
			sqx_q      <= '0;
			sqz_q      <= '0;
			xhi_q      <= '0;
			xlo_q      <= '0;
			zhi_q      <= '0;
			zlo_q      <= '0;
			nn1_q      <= '0;
			acc_q      <= '0;
			mcand_q    <= '0;
			mplier_q   <= '0;
			var_q      <= '0;
			x_mean_q   <= '0;
			z_mean_q   <= '0;
			s_mean_q   <= '0;
			x_dev_q    <= '0;
			z_dev_q    <= '0;
			x_span_q   <= '0;
			z_span_q   <= '0;
		end else begin
			v_s1 <= mem_re;
			v_s2 <= v_s1;
			if (m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						if (head.item.cmd == CMD_PUSH) begin
							if (!cfg_valid) begin
								ws_q <= (ws_q == wl_last) ? '0 : ws_q + AW'(1);
								if (vc_q != wl_q) begin
									vc_q <= vc_q + NW'(1);
								end
							end
						end else begin
							n_q       <= vc_q;
							rem_cnt_q <= vc_q;
							rd_ptr_q  <= (ws_q == '0) ? wl_last : ws_q - AW'(1);
							first_q   <= 1'b1;
							sx_q      <= '0;
							sz_q      <= '0;
							ssum_q    <= '0;
							sqx_q     <= '0;
							sqz_q     <= '0;
							x_mean_q  <= '0;
							z_mean_q  <= '0;
							s_mean_q  <= '0;
							x_dev_q   <= '0;
							z_dev_q   <= '0;
							x_span_q  <= '0;
							z_span_q  <= '0;
							ch_q      <= 1'b0;
							wait_q    <= 1'b0;
							state_q   <= (vc_q == '0) ? ST_DONE : ST_WALK;
						end
					end
				end
				ST_WALK: begin
					nn1_q <= DVW'(n_q) * DVW'(n_q - NW'(1));
					if (mem_re) begin
						rem_cnt_q <= rem_cnt_q - NW'(1);
						rd_ptr_q  <= (rd_ptr_q == '0) ? wl_last : rd_ptr_q - AW'(1);
					end
					if (v_s2) begin
						first_q <= 1'b0;
						sx_q    <= sx_q + {{NW{x_s2[PosW-1]}}, x_s2};
						sz_q    <= sz_q + {{NW{z_s2[PosW-1]}}, z_s2};
						ssum_q  <= ssum_q + SW'(sum_s2);
						sqx_q   <= sqx_q + QW'(sqx_s2);
						sqz_q   <= sqz_q + QW'(sqz_s2);
						if (first_q || $signed(x_s2) > $signed(xhi_q)) xhi_q <= x_s2;
						if (first_q || $signed(x_s2) < $signed(xlo_q)) xlo_q <= x_s2;
						if (first_q || $signed(z_s2) > $signed(zhi_q)) zhi_q <= z_s2;
						if (first_q || $signed(z_s2) < $signed(zlo_q)) zlo_q <= z_s2;
					end else if (rem_cnt_q == '0 && !v_s1) begin
						x_span_q <= xhi_q - xlo_q;
						z_span_q <= zhi_q - zlo_q;
						state_q  <= ST_MEAN_X;
					end
				end
				ST_MEAN_X: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (div_done) begin
						x_mean_q <= sx_q[SW-1] ? (~div_q[PosW-1:0] + PosW'(1)) : div_q[PosW-1:0];
						wait_q   <= 1'b0;
						state_q  <= ST_MEAN_Z;
					end
				end
				ST_MEAN_Z: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (div_done) begin
						z_mean_q <= sz_q[SW-1] ? (~div_q[PosW-1:0] + PosW'(1)) : div_q[PosW-1:0];
						wait_q   <= 1'b0;
						state_q  <= ST_MEAN_S;
					end
				end
				ST_MEAN_S: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (div_done) begin
						s_mean_q <= div_q[PosW-1:0];
						wait_q   <= 1'b0;
						state_q  <= (n_q < NW'(2)) ? ST_DONE : ST_VMUL;
					end
				end
				ST_VMUL: begin
					if (!wait_q) begin
						acc_q    <= '0;
						mcand_q  <= ch_q ? VW'(sqz_q) : VW'(sqx_q);
						mplier_q <= SW'(n_q);
						wait_q   <= 1'b1;
					end else if (mplier_q == '0) begin
						wait_q  <= 1'b0;
						state_q <= ST_VSQ;
					end else begin
						if (mplier_q[0]) acc_q <= acc_q + mcand_q;
						mcand_q  <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
					end
				end
				ST_VSQ: begin
					if (!wait_q) begin
						mcand_q  <= VW'(sa);
						mplier_q <= sa;
						wait_q   <= 1'b1;
					end else if (mplier_q == '0) begin
						wait_q  <= 1'b0;
						state_q <= ST_VDIV;
					end else begin
						if (mplier_q[0]) acc_q <= acc_q - mcand_q;
						mcand_q  <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
					end
				end
				ST_VDIV: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (div_done) begin
						var_q   <= div_q[63:0];
						wait_q  <= 1'b0;
						state_q <= ST_VSQRT;
					end
				end
				ST_VSQRT: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (sqrt_done) begin
						wait_q <= 1'b0;
						if (!ch_q) begin
							x_dev_q <= sqrt_root;
							ch_q    <= 1'b1;
							state_q <= ST_VMUL;
						end else begin
							z_dev_q <= sqrt_root;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= OutDataW'({VsW'(n_q), z_span_q, x_span_q, z_dev_q,
							x_dev_q, s_mean_q, z_mean_q, x_mean_q});
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_valid) begin
				wl_q <= clamp_wl(cfg_data);
				ws_q <= '0;
				vc_q <= '0;
			end
		end
	end

endmodule

FILE: rtl/wps_checker.sv
// ----------------------------------------------------------------------------
// window position statistics checker
// port level properties of the result channel
// ----------------------------------------------------------------------------
module wps_port_props (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [wps_pkg::OutDataW-1:0]  m_tdata
);
	import wps_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[OffVs+VsW-1:OffVs] == '0) |-> (m_tdata[OffVs-1:0] == '0))
		else $error("empty window gave nonzero statistics");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[OffVs+VsW-1:OffVs] == VsW'(1))
		|-> (m_tdata[OffVs-1:OffDev] == '0))
		else $error("single sample gave nonzero deviation or span");

endmodule

bind window_position_statistics_top wps_port_props u_wps_port_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: verif/wps_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window position statistics checker
// tracks the sample window on each transfer, predicts report results and
// compares every m_* transfer field by field in arrival order
// ----------------------------------------------------------------------------
module wps_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [wps_pkg::InDataW-1:0]   s_tdata,
	input  logic [0:0]                    s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [wps_pkg::OutDataW-1:0]  m_tdata,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [wps_pkg::CfgW-1:0]      cfg_data,
	output int                            errors,
	output int                            pending
);
	import wps_pkg::*;

	localparam int Depth = 1024;

	typedef struct {
		logic [31:0] x_mean;
		logic [31:0] z_mean;
		logic [31:0] sum_mean;
		logic [31:0] x_dev;
		logic [31:0] z_dev;
		logic [31:0] x_span;
		logic [31:0] z_span;
		logic [10:0] n;
	} stats_t;

	logic [31:0] pos_hist [2][Depth];
	logic [31:0] sum_hist [Depth];
	int unsigned write_slot;
	int unsigned valid_count;
	int unsigned window_len;
	stats_t      stats_q[$];

	assign pending = stats_q.size();

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic int unsigned slot_back(input int unsigned k);
		return (write_slot + window_len - k) % window_len;
	endfunction

	function automatic void channel_stats(input int ch, input int unsigned n,
			output logic [31:0] mean, output logic [31:0] dev, output logic [31:0] span);
		longint s, v, lo, hi, q;
		logic [127:0] sq, num;
		logic [63:0] a;
		s = 0; lo = 0; hi = 0; sq = 0;
		for (int unsigned k = 1; k <= n; k++) begin
			v = longint'($signed(pos_hist[ch][slot_back(k)]));
			a = v < 0 ? -v : v;
			s += v;
			sq += 128'(a) * 128'(a);
			if (k == 1 || v > hi) hi = v;
			if (k == 1 || v < lo) lo = v;
		end
		q = s / longint'(n);
		mean = q[31:0];
		q = hi - lo;
		span = q[31:0];
		if (n < 2) begin
			dev = 0;
		end else begin
			a = s < 0 ? -s : s;
			num = sq * 128'(n) - 128'(a) * 128'(a);
			num = num / (128'(n) * 128'(n - 1));
			a = floor_sqrt(num[63:0]);
			dev = a[31:0];
		end
	endfunction

	function automatic stats_t predict_report();
		stats_t r;
		logic [63:0] ssum;
		int unsigned n;
		n = valid_count;
		r = '{default: '0};
		if (n == 0) return r;
		channel_stats(0, n, r.x_mean, r.x_dev, r.x_span);
		channel_stats(1, n, r.z_mean, r.z_dev, r.z_span);
		ssum = 0;
		for (int unsigned k = 1; k <= n; k++) ssum += sum_hist[slot_back(k)];
		ssum = ssum / n;
		r.sum_mean = ssum[31:0];
		r.n = n[10:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		stats_t e;
		int unsigned w;
		if (!arst_n) begin
			write_slot <= 0;
			valid_count <= 0;
			window_len <= 1024;
			errors <= 0;
			stats_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				w = cfg_data;
				if (w < 1) w = 1;
				if (w > Depth) w = Depth;
				window_len <= w;
				write_slot <= 0;
				valid_count <= 0;
			end
			if (s_tvalid && s_tready) begin
				if (cmd_t'(s_tuser[0]) == CMD_PUSH) begin
					pos_hist[0][write_slot] <= s_tdata[31:0];
					pos_hist[1][write_slot] <= s_tdata[63:32];
					sum_hist[write_slot] <= s_tdata[95:64];
					write_slot <= (write_slot + 1) % window_len;
					if (valid_count < window_len) valid_count <= valid_count + 1;
				end else begin
					stats_q.insert(stats_q.size(), predict_report());
				end
			end
			if (m_tvalid && m_tready) begin
				if (stats_q.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
				end else begin
					e = stats_q.pop_front();
					if (m_tdata[31:0] !== e.x_mean)
						report_mismatch("x_mean", m_tdata[31:0], e.x_mean);
					if (m_tdata[63:32] !== e.z_mean)
						report_mismatch("z_mean", m_tdata[63:32], e.z_mean);
					if (m_tdata[95:64] !== e.sum_mean)
						report_mismatch("sum_mean", m_tdata[95:64], e.sum_mean);
					if (m_tdata[127:96] !== e.x_dev)
						report_mismatch("x_deviation", m_tdata[127:96], e.x_dev);
					if (m_tdata[159:128] !== e.z_dev)
						report_mismatch("z_deviation", m_tdata[159:128], e.z_dev);
					if (m_tdata[191:160] !== e.x_span)
						report_mismatch("x_span", m_tdata[191:160], e.x_span);
					if (m_tdata[223:192] !== e.z_span)
						report_mismatch("z_span", m_tdata[223:192], e.z_span);
					if (m_tdata[234:224] !== e.n)
						report_mismatch("valid_samples", 32'(m_tdata[234:224]), 32'(e.n));
				end
			end
		end
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window position statistics testbench
// directed edge cases then random push/report traffic over several window
// lengths and idle patterns, checked by wps_checker
// ----------------------------------------------------------------------------
module tb_top;
	import wps_pkg::*;

	localparam longint CycleLimit = 20000000;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 s_tvalid = 0;
	logic                 s_tready;
	logic [InDataW-1:0]   s_tdata = '0;
	logic [0:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 0;
	logic [OutDataW-1:0]  m_tdata;
	logic                 cfg_valid = 0;
	logic                 cfg_ready;
	logic [CfgW-1:0]      cfg_data = '0;
	int                   errors;
	int                   pending;
	int                   idle_mode = 0;
	bit                   hold_req = 0;
	longint               cycles = 0;

	always #1 clk = ~clk;

	window_position_statistics_top dut (.*);

	wps_checker u_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 0;
				for (int i = 0; i < 4000; i++) @(posedge clk);
				hold_req = 0;
			end
			if (idle_mode == 2)
				m_tready <= ($urandom_range(99) >= 88);
			else if (idle_mode == 3)
				m_tready <= ($urandom_range(99) >= 6);
			else
				m_tready <= 1;
		end
	end

	function automatic logic [31:0] pick_pos();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed($urandom_range(2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_sum();
		case ($urandom_range(5))
			0: return 32'hffff_ffff;
			1: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	task automatic send(input cmd_t cmd, input logic [31:0] x, input logic [31:0] z,
			input logic [31:0] s);
		if (idle_mode == 1 || idle_mode == 3) begin
			while ($urandom_range(99) < (idle_mode == 1 ? 88 : 6)) begin
				s_tvalid <= 0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= {s, z, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic push_rand();
		send(CMD_PUSH, pick_pos(), pick_pos(), pick_sum());
	endtask

	task automatic report();
		send(CMD_REPORT, $urandom, $urandom, $urandom);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_window(input logic [CfgW-1:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
	endtask

	initial begin
		int wl [12] = '{3, 1, 2, 17, 1024, 2047, 0, 5, 64, 9, 200, 40};
		int per;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty, single sample, extremes
		report();
		send(CMD_PUSH, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
		report();
		send(CMD_PUSH, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
		report();
		send(CMD_PUSH, 32'h0, 32'hffff_ffff, 32'h0);
		send(CMD_PUSH, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
		report();
		write_window(0);
		send(CMD_PUSH, 32'd5, -32'sd5, 32'd7);
		send(CMD_PUSH, -32'sd9, 32'd9, 32'd3);
		report();
		write_window(2047);
		report();
		send(CMD_PUSH, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
		send(CMD_PUSH, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
		report();

		per = 1820 / 12;
		foreach (wl[p]) begin
			write_window(wl[p]);
			idle_mode = p % 4;
			for (int i = 0; i < per; i++) begin
				if (p == 3 && i == 20) hold_req = 1;
				if ($urandom_range(7) == 0) report();
				else push_rand();
			end
			if (p == 3) begin
				idle_mode = 0;
				for (int i = 0; i < 12; i++) report();
			end
		end

		drain();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/wps_pkg.sv
rtl/wps_front.sv
rtl/wps_div.sv
rtl/wps_sqrt.sv
rtl/wps_back.sv
rtl/window_position_statistics_top.sv
rtl/wps_checker.sv
verif/wps_checker.sv
verif/tb_top.sv
